[rtl/kls_pkg.sv]
// ----------------------------------------------------------------------------
// kls_pkg: keyframe sampler shared types and constants
// Operation codes, beat payload types and the per-cell key record.
// ----------------------------------------------------------------------------
`default_nettype none
package kls_pkg;
   localparam int MaxKeysDefault = 64;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [15:0]        key_frame;
      logic signed [31:0] val_x;
      logic signed [31:0] val_y;
      logic signed [31:0] val_z;
      logic signed [31:0] val_w;
      logic [31:0]        query_frame;
   } req_type;

   typedef struct packed {
      logic [15:0]        frame_floor;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               table_empty;
   } rsp_type;

   // one keyframe as it travels along the chain
   typedef struct packed {
      logic [15:0]  frame;
      logic [127:0] vals;
   } key_type;
endpackage
`default_nettype wire

[rtl/kls_if.sv]
// ----------------------------------------------------------------------------
// kls_if: valid/ready channel
// Carries one payload of type T per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface kls_if #(parameter type T = logic) (input wire logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/kls_cell.sv]
// ----------------------------------------------------------------------------
// kls_cell: one key storage cell
// Holds a key, and hands it to its left neighbour when the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none
module kls_cell import kls_pkg::*; (
   input  wire logic    clock,
   input  wire logic    load,
   input  wire logic    shift,
   input  wire key_type load_key,
   input  wire key_type right_key,
   output key_type      key
);
   key_type key_ff;

   // load takes priority over rotation
   always_ff @(posedge clock) begin
      if (load) begin
         key_ff <= load_key;
      end else if (shift) begin
         key_ff <= right_key;
      end
   end
   assign key = key_ff;
endmodule
`default_nettype wire

[rtl/kls_div.sv]
// ----------------------------------------------------------------------------
// kls_div: restoring divider
// 32-bit dividend over 32-bit divisor, one quotient bit per cycle; 16-bit result.
// ----------------------------------------------------------------------------
`default_nettype none
module kls_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] num,
   input  wire logic [31:0] den,
   output logic             done,
   output logic [15:0]      quo
);
   logic [32:0] rem_ff, rem_in;
   logic [47:0] num_ff, num_in;
   logic [31:0] den_ff;
   logic [15:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   // quotient = (num << 16) / den: 48 dividend bits
   always_comb begin
      trial   = {rem_ff[31:0], num_ff[47]} - {1'b0, den_ff};
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         num_in  = {num, 16'd0};
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[46:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[47]};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end
   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

[rtl/keyframe_linear_sampler.sv]
// ----------------------------------------------------------------------------
// keyframe_linear_sampler: keyframe table with linear sampling
//
//  channel | dir | payload
//  req     | in  | op, key_frame, val_x..val_w, query_frame
//  rsp     | out | frame_floor, out_x..out_w, table_empty
//
// Clear and append leave the block in idle and may follow back to back.
// A sample on an empty table, or one that clamps, goes straight from idle to
// the output state. Otherwise the ring of key cells rotates once (one key pair
// per cycle at cell 0/1): an exact match or no bracket ends there. A blend then
// adds a serial division, four 33x17 multiplies and one add.
// Synchronous reset empties the table. Results wait in an output register;
// a finished sample holds in its last state only while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_linear_sampler import kls_pkg::*; #(
   parameter int MAX_KEYS = MaxKeysDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   kls_if.sink       req,
   kls_if.source     rsp
);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int IW = $clog2(MAX_KEYS);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_ADD  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] rot_ff, rot_in;    // keys passed cell 0 so far
   logic [CW-1:0] step_ff, step_in;
   logic [31:0]   q_ff;
   logic          found_ff, found_in, interp_ff, interp_in;
   key_type       k0_ff, k1_ff;      // bracketing keys
   key_type       last_ff;           // most recently stored key
   logic [1:0]    lane_ff, lane_in;
   logic signed [48:0] prod_ff [4];
   rsp_type       res_ff, res_in;
   rsp_type       out_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;
   logic          key_store;

   key_type cell_key [MAX_KEYS];
   logic    shift;
   logic    load [MAX_KEYS];
   key_type new_key;

   // ring of key cells, each cell reads its right neighbour and cell MAX_KEYS-1 reads cell 0: left rotation
   assign new_key = '{frame: req.data.key_frame,
                      vals: {req.data.val_x, req.data.val_y,
                             req.data.val_z, req.data.val_w}};
   for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
      assign load[g] = req.valid && req.ready && req.data.op == OP_APPEND
                       && count_ff == CW'(g);
      kls_cell u_cell (
         .clock     (clock),
         .load      (load[g]),
         .shift     (shift),
         .load_key  (new_key),
         .right_key (cell_key[(g + 1) % MAX_KEYS]),
         .key       (cell_key[g])
      );
   end

   // an append that fits in the table
   assign key_store = req.valid && req.ready && req.data.op == OP_APPEND
                      && count_ff < CW'(MAX_KEYS);

   logic [31:0] t0, t1, tl;
   logic        div_start, div_done;
   logic [15:0] frac;
   assign t0 = {cell_key[0].frame, 16'd0};
   assign t1 = {cell_key[1 % MAX_KEYS].frame, 16'd0};
   assign tl = {last_ff.frame, 16'd0};

   kls_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (q_ff - {k0_ff.frame, 16'd0}),
      .den   ({k1_ff.frame, 16'd0} - {k0_ff.frame, 16'd0}),
      .done  (div_done),
      .quo   (frac)
   );

   function automatic logic signed [31:0] comp(input logic [127:0] v, input int c);
      comp = v[127-32*c -: 32];
   endfunction

   assign req.ready = state_ff == ST_IDLE;
   assign shift     = state_ff == ST_SCAN;
   assign rsp_load  = state_ff == ST_OUT && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      logic signed [48:0] sh;
      state_in     = state_ff;
      count_in     = count_ff;
      rot_in       = rot_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      interp_in    = interp_ff;
      lane_in      = lane_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      sh = '0;
      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               case (op_type'(req.data.op))
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (count_ff < CW'(MAX_KEYS)) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_SAMPLE: begin
                     res_in = '{frame_floor: req.data.query_frame[31:16],
                                out_x: '0, out_y: '0, out_z: '0, out_w: '0,
                                table_empty: count_ff == '0};
                     found_in  = 1'b0;
                     interp_in = 1'b0;
                     if (count_ff == '0) begin
                        state_in = ST_OUT;
                     end else if (req.data.query_frame <= t0) begin
                        res_in.out_x = comp(cell_key[0].vals, 0);
                        res_in.out_y = comp(cell_key[0].vals, 1);
                        res_in.out_z = comp(cell_key[0].vals, 2);
                        res_in.out_w = comp(cell_key[0].vals, 3);
                        state_in = ST_OUT;
                     end else if (req.data.query_frame >= tl) begin
                        res_in.out_x = comp(last_ff.vals, 0);
                        res_in.out_y = comp(last_ff.vals, 1);
                        res_in.out_z = comp(last_ff.vals, 2);
                        res_in.out_w = comp(last_ff.vals, 3);
                        state_in = ST_OUT;
                     end else begin
                        rot_in   = '0;
                        step_in  = CW'(1);
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // pair (cell0, cell1) = keys (step-1, step)
            if (!found_ff && step_ff < count_ff) begin
               if (t1 == q_ff) begin
                  found_in = 1'b1;
                  res_in.out_x = comp(cell_key[1 % MAX_KEYS].vals, 0);
                  res_in.out_y = comp(cell_key[1 % MAX_KEYS].vals, 1);
                  res_in.out_z = comp(cell_key[1 % MAX_KEYS].vals, 2);
                  res_in.out_w = comp(cell_key[1 % MAX_KEYS].vals, 3);
               end else if (t1 > q_ff) begin
                  found_in  = 1'b1;
                  interp_in = t0 < q_ff;
               end
            end
            step_in = step_ff + CW'(1);
            rot_in  = rot_ff + IW'(1);
            if (rot_ff == IW'(MAX_KEYS - 1)) begin
               if (interp_in) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIV: begin
            lane_in = '0;
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            lane_in = lane_ff + 2'd1;
            if (lane_ff == 2'd3) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int c = 0; c < 4; c++) begin
               sh = prod_ff[c] >>> 16;
               case (c)
                  0: res_in.out_x = comp(k0_ff.vals, 0) + sh[31:0];
                  1: res_in.out_y = comp(k0_ff.vals, 1) + sh[31:0];
                  2: res_in.out_z = comp(k0_ff.vals, 2) + sh[31:0];
                  default: res_in.out_w = comp(k0_ff.vals, 3) + sh[31:0];
               endcase
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hand over once the output register is free
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         interp_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         interp_ff    <= interp_in;
      end
      rot_ff  <= rot_in;
      step_ff <= step_in;
      lane_ff <= lane_in;
      res_ff  <= res_in;
      if (rsp_load) begin
         out_ff <= res_ff;
      end
      if (key_store) begin
         last_ff <= new_key;
      end
      if (state_ff == ST_IDLE) begin
         q_ff <= req.data.query_frame;
      end
      // capture the bracketing pair when first found
      if (state_ff == ST_SCAN && !found_ff && found_in) begin
         k0_ff <= cell_key[0];
         k1_ff <= cell_key[1 % MAX_KEYS];
      end
      // one 33x17 multiply per cycle
      if (state_ff == ST_MUL) begin
         prod_ff[lane_ff] <= (comp(k1_ff.vals, int'(lane_ff))
                              - comp(k0_ff.vals, int'(lane_ff)))
                             * $signed({1'b0, frac});
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = out_ff;

`ifndef ASSERT_OFF
   // the ring must turn exactly once: scan ends after a full pass
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && rot_ff == IW'(MAX_KEYS - 1) |=> state_ff != ST_SCAN)
      else $error("scan ran past one rotation");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS)) else $error("key count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("beat taken while busy");
`endif
endmodule
`default_nettype wire
